### design/twsm_pkg.sv
// ----------------------------------------------------------------------------
// twsm_pkg: shared types and constants for the three-wire serial master
// Payload structures for the tick and result channels, the configuration
// bundle and the register map of the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

package twsm_pkg;

	localparam int unsigned LenW  = 20;
	localparam int unsigned AddrW = 4;
	localparam int unsigned DataW = 32;

	// Register indexes on the configuration port (byte address is 4 * index)
	localparam logic [1:0] RegHalfBit    = 2'd0;
	localparam logic [1:0] RegHold       = 2'd1;
	localparam logic [1:0] RegResyncLow  = 2'd2;
	localparam logic [1:0] RegResyncWait = 2'd3;

	localparam logic [LenW-1:0] HalfBitReset    = 20'd250;
	localparam logic [LenW-1:0] HoldReset       = 20'd150;
	localparam logic [LenW-1:0] ResyncLowReset  = 20'd50;
	localparam logic [LenW-1:0] ResyncWaitReset = 20'd100000;

	// Transaction modes
	localparam logic [1:0] ModeRead   = 2'd0;
	localparam logic [1:0] ModeWrite  = 2'd1;
	localparam logic [1:0] ModeResync = 2'd2;
	localparam logic [1:0] ModePoll   = 2'd3;

	localparam logic [7:0] WriteFlag = 8'h80;
	localparam logic [7:0] RegDeltaX = 8'h03;
	localparam logic [7:0] RegDeltaY = 8'h04;

	typedef struct packed {
		logic       start_req;
		logic [1:0] mode;
		logic [6:0] address;
		logic [7:0] write_data;
		logic       sdio_in;
	} item_t;

	typedef struct packed {
		logic              sclk;
		logic              sdio_drive_low;
		logic              busy_res;
		logic              done_res;
		logic [7:0]        read_data;
		logic signed [7:0] delta_x;
		logic signed [7:0] delta_y;
	} result_t;

	typedef struct packed {
		logic [LenW-1:0] half_bit_cycles;
		logic [LenW-1:0] hold_cycles;
		logic [LenW-1:0] resync_low_cycles;
		logic [LenW-1:0] resync_wait_cycles;
	} cfg_t;

endpackage

`default_nettype wire

### design/twsm_cfg.sv
// ----------------------------------------------------------------------------
// twsm_cfg: configuration registers
// Four 20-bit timing registers behind an APB-style port with no wait states.
// ----------------------------------------------------------------------------
`default_nettype none

module twsm_cfg
	import twsm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [DataW-1:0] pwdata,
	output logic      [DataW-1:0] prdata,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_bit_cycles    <= HalfBitReset;
			cfg_q.hold_cycles        <= HoldReset;
			cfg_q.resync_low_cycles  <= ResyncLowReset;
			cfg_q.resync_wait_cycles <= ResyncWaitReset;
		end else if (wr_en) begin
			case (reg_idx)
				RegHalfBit:    cfg_q.half_bit_cycles    <= pwdata[LenW-1:0];
				RegHold:       cfg_q.hold_cycles        <= pwdata[LenW-1:0];
				RegResyncLow:  cfg_q.resync_low_cycles  <= pwdata[LenW-1:0];
				RegResyncWait: cfg_q.resync_wait_cycles <= pwdata[LenW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			RegHalfBit:    prdata = {{(DataW-LenW){1'b0}}, cfg_q.half_bit_cycles};
			RegHold:       prdata = {{(DataW-LenW){1'b0}}, cfg_q.hold_cycles};
			RegResyncLow:  prdata = {{(DataW-LenW){1'b0}}, cfg_q.resync_low_cycles};
			RegResyncWait: prdata = {{(DataW-LenW){1'b0}}, cfg_q.resync_wait_cycles};
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### design/twsm_seq.sv
// ----------------------------------------------------------------------------
// twsm_seq: pin sequencer
// Advances the link state by one tick when step is high and presents the
// pin levels and captured bytes as they stand after that tick.
// ----------------------------------------------------------------------------
`default_nettype none

module twsm_seq
	import twsm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  step,
	input  wire item_t tick,
	input  wire cfg_t  cfg,
	output result_t    res
);

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_W_LOW   = 4'd1,
		PH_W_HIGH  = 4'd2,
		PH_HOLD    = 4'd3,
		PH_R_LOW   = 4'd4,
		PH_R_HIGH  = 4'd5,
		PH_RS_LOW  = 4'd6,
		PH_RS_WAIT = 4'd7
	} phase_t;

	phase_t          phase_q, phase_nx;
	logic [2:0]      bit_q, bit_nx;
	logic [LenW-1:0] wait_q, wait_nx;
	logic [7:0]      shift_q, shift_nx;
	logic [7:0]      pend_q, pend_nx;
	logic [1:0]      mode_q, mode_nx;
	logic            second_q, second_nx;
	logic            clk_lvl_q, clk_lvl_nx;
	logic            drv_q, drv_nx;
	logic [7:0]      cap_q, cap_nx;
	logic [7:0]      cap_x_q, cap_x_nx;
	logic [7:0]      cap_y_q, cap_y_nx;
	logic            done;
	logic [7:0]      sampled;

	// A programmed length of zero behaves as one tick.
	function automatic logic [LenW-1:0] load_len(input logic [LenW-1:0] n);
		return (n == '0) ? '0 : n - 1'b1;
	endfunction

	always_comb begin
		phase_nx   = phase_q;
		bit_nx     = bit_q;
		wait_nx    = wait_q;
		shift_nx   = shift_q;
		pend_nx    = pend_q;
		mode_nx    = mode_q;
		second_nx  = second_q;
		clk_lvl_nx = clk_lvl_q;
		drv_nx     = drv_q;
		cap_nx     = cap_q;
		cap_x_nx   = cap_x_q;
		cap_y_nx   = cap_y_q;
		done       = 1'b0;
		sampled    = shift_q;
		sampled[bit_q] = tick.sdio_in;

		if (phase_q == PH_IDLE) begin
			if (tick.start_req) begin
				mode_nx   = tick.mode;
				second_nx = 1'b0;
				if (tick.mode == ModeResync) begin
					phase_nx   = PH_RS_LOW;
					clk_lvl_nx = 1'b0;
					drv_nx     = 1'b0;
					wait_nx    = load_len(cfg.resync_low_cycles);
				end else begin
					case (tick.mode)
						ModeRead:  shift_nx = {1'b0, tick.address};
						ModeWrite: shift_nx = {1'b0, tick.address} | WriteFlag;
						default:   shift_nx = RegDeltaX;
					endcase
					if (tick.mode == ModeWrite) begin
						pend_nx = tick.write_data;
					end
					bit_nx     = 3'd7;
					phase_nx   = PH_W_LOW;
					clk_lvl_nx = 1'b0;
					drv_nx     = !shift_nx[7];
					wait_nx    = load_len(cfg.half_bit_cycles);
				end
			end
		end else if (wait_q != '0) begin
			wait_nx = wait_q - 1'b1;
		end else begin
			case (phase_q)
				PH_W_LOW: begin
					phase_nx   = PH_W_HIGH;
					clk_lvl_nx = 1'b1;
					wait_nx    = load_len(cfg.half_bit_cycles);
				end
				PH_W_HIGH: begin
					if (bit_q != 3'd0) begin
						bit_nx     = bit_q - 1'b1;
						phase_nx   = PH_W_LOW;
						clk_lvl_nx = 1'b0;
						drv_nx     = !shift_q[bit_nx];
						wait_nx    = load_len(cfg.half_bit_cycles);
					end else if (mode_q == ModeWrite) begin
						if (!second_q) begin
							// Address sent; now the data byte.
							second_nx  = 1'b1;
							shift_nx   = pend_q;
							bit_nx     = 3'd7;
							phase_nx   = PH_W_LOW;
							clk_lvl_nx = 1'b0;
							drv_nx     = !pend_q[7];
							wait_nx    = load_len(cfg.half_bit_cycles);
						end else begin
							phase_nx   = PH_IDLE;
							clk_lvl_nx = 1'b1;
							drv_nx     = 1'b0;
							bit_nx     = 3'd0;
							wait_nx    = '0;
							done       = 1'b1;
						end
					end else begin
						phase_nx   = PH_HOLD;
						clk_lvl_nx = 1'b1;
						drv_nx     = 1'b0;
						wait_nx    = load_len(cfg.hold_cycles);
					end
				end
				PH_HOLD: begin
					phase_nx   = PH_R_LOW;
					clk_lvl_nx = 1'b0;
					bit_nx     = 3'd7;
					shift_nx   = '0;
					wait_nx    = load_len(cfg.half_bit_cycles);
				end
				PH_R_LOW: begin
					phase_nx   = PH_R_HIGH;
					clk_lvl_nx = 1'b1;
					wait_nx    = load_len(cfg.half_bit_cycles);
				end
				PH_R_HIGH: begin
					shift_nx = sampled;
					if (bit_q != 3'd0) begin
						bit_nx     = bit_q - 1'b1;
						phase_nx   = PH_R_LOW;
						clk_lvl_nx = 1'b0;
						wait_nx    = load_len(cfg.half_bit_cycles);
					end else if (mode_q == ModePoll && !second_q) begin
						// X delta held back until the Y read completes.
						pend_nx    = sampled;
						second_nx  = 1'b1;
						shift_nx   = RegDeltaY;
						bit_nx     = 3'd7;
						phase_nx   = PH_W_LOW;
						clk_lvl_nx = 1'b0;
						drv_nx     = !RegDeltaY[7];
						wait_nx    = load_len(cfg.half_bit_cycles);
					end else begin
						if (mode_q == ModePoll) begin
							cap_x_nx = pend_q;
							cap_y_nx = sampled;
						end else begin
							cap_nx = sampled;
						end
						phase_nx   = PH_IDLE;
						clk_lvl_nx = 1'b1;
						drv_nx     = 1'b0;
						bit_nx     = 3'd0;
						wait_nx    = '0;
						done       = 1'b1;
					end
				end
				PH_RS_LOW: begin
					phase_nx   = PH_RS_WAIT;
					clk_lvl_nx = 1'b1;
					wait_nx    = load_len(cfg.resync_wait_cycles);
				end
				PH_RS_WAIT: begin
					phase_nx   = PH_IDLE;
					clk_lvl_nx = 1'b1;
					drv_nx     = 1'b0;
					bit_nx     = 3'd0;
					wait_nx    = '0;
					done       = 1'b1;
				end
				default: begin
					phase_nx   = PH_IDLE;
					clk_lvl_nx = 1'b1;
					drv_nx     = 1'b0;
					bit_nx     = 3'd0;
					wait_nx    = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_q     <= '0;
			wait_q    <= '0;
			shift_q   <= '0;
			pend_q    <= '0;
			mode_q    <= '0;
			second_q  <= 1'b0;
			clk_lvl_q <= 1'b1;
			drv_q     <= 1'b0;
			cap_q     <= '0;
			cap_x_q   <= '0;
			cap_y_q   <= '0;
		end else if (step) begin
			phase_q   <= phase_nx;
			bit_q     <= bit_nx;
			wait_q    <= wait_nx;
			shift_q   <= shift_nx;
			pend_q    <= pend_nx;
			mode_q    <= mode_nx;
			second_q  <= second_nx;
			clk_lvl_q <= clk_lvl_nx;
			drv_q     <= drv_nx;
			cap_q     <= cap_nx;
			cap_x_q   <= cap_x_nx;
			cap_y_q   <= cap_y_nx;
		end
	end

	always_comb begin
		res.sclk           = clk_lvl_nx;
		res.sdio_drive_low = drv_nx;
		res.busy_res       = (phase_nx != PH_IDLE);
		res.done_res       = done;
		res.read_data      = cap_nx;
		res.delta_x        = cap_x_nx;
		res.delta_y        = cap_y_nx;
	end

endmodule

`default_nettype wire

### design/three_wire_sensor_serial_master.sv
// ----------------------------------------------------------------------------
// three_wire_sensor_serial_master: half-duplex three-wire serial link master
// Tick-driven master for a clock pin and an open-drain data pin, with
// register read, register write, resync and two-register motion poll.
// ----------------------------------------------------------------------------
// Each transaction on the item channel is one tick of the pin sequencer and
// yields exactly one result transaction showing the pins and captured bytes
// after that tick. A tick is accepted every clock cycle while results are
// being taken; each tick passes the input register, the combinational
// sequencer update and the result register. The user writes the timing
// registers through the APB port only while idle; the block does not enforce this.
`default_nettype none

module three_wire_sensor_serial_master
	import twsm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire item_t            item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output result_t               result,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [DataW-1:0] pwdata,
	output logic      [DataW-1:0] prdata,
	output logic                  pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t seq_res;
	result_t result_q;
	logic    result_valid_q;
	logic    advance;

	assign pready     = 1'b1;
	assign advance    = !result_valid_q || result_ready;
	assign item_ready = !valid_s1 || advance;

	twsm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	twsm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.tick   (item_s1),
		.cfg    (cfg),
		.res    (seq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				result_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (advance && valid_s1) begin
			result_q <= seq_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A finished transaction is never reported as still busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.done_res |-> !result.busy_res)
		else $error("done_res raised while busy_res is set");

	// With the result side empty the block must take a new tick.
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("item_ready low with no result pending");

	// Outside a transaction the clock idles high and the data pin is released.
	a_idle_pins: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.busy_res |-> result.sclk && !result.sdio_drive_low)
		else $error("pins not in idle state while not busy");

endmodule

`default_nettype wire

### tb/twsm_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twsm_tb_pkg: tick predictor and result scoreboard for the serial master
// Follows the pin sequencer tick by tick from the accepted ticks, keeps the
// predicted result of each one in order and checks every result transaction
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------

package twsm_tb_pkg;
	import twsm_pkg::*;

	typedef enum logic [3:0] {
		SeqIdle,
		SeqWrLow,
		SeqWrHigh,
		SeqHold,
		SeqRdLow,
		SeqRdHigh,
		SeqRsLow,
		SeqRsWait
	} seq_phase_e;

	class pin_sequencer_scoreboard;
		cfg_t            timing;
		seq_phase_e      ph;
		logic [2:0]      bit_idx;
		logic [LenW-1:0] countdown;
		logic [7:0]      shifter;
		logic [7:0]      held_byte;
		logic [1:0]      cur_mode;
		logic            second_pass;
		logic            sclk_lvl;
		logic            pull_low;
		logic [7:0]      last_read;
		logic [7:0]      last_dx;
		logic [7:0]      last_dy;
		result_t         pin_results[$];
		int unsigned     errors;
		int unsigned     ticks;
		int unsigned     checked;
		int unsigned     completed;
		int unsigned     started[4];

		function new();
			timing.half_bit_cycles    = HalfBitReset;
			timing.hold_cycles        = HoldReset;
			timing.resync_low_cycles  = ResyncLowReset;
			timing.resync_wait_cycles = ResyncWaitReset;
			ph          = SeqIdle;
			bit_idx     = '0;
			countdown   = '0;
			shifter     = '0;
			held_byte   = '0;
			cur_mode    = '0;
			second_pass = 1'b0;
			sclk_lvl    = 1'b1;
			pull_low    = 1'b0;
			last_read   = '0;
			last_dx     = '0;
			last_dy     = '0;
			errors      = 0;
			ticks       = 0;
			checked     = 0;
			completed   = 0;
			foreach (started[i]) started[i] = 0;
		endfunction

		function void set_timing(logic [1:0] idx, logic [DataW-1:0] value);
			case (idx)
				RegHalfBit:    timing.half_bit_cycles    = value[LenW-1:0];
				RegHold:       timing.hold_cycles        = value[LenW-1:0];
				RegResyncLow:  timing.resync_low_cycles  = value[LenW-1:0];
				RegResyncWait: timing.resync_wait_cycles = value[LenW-1:0];
				default: ;
			endcase
		endfunction

		function bit busy();
			return ph != SeqIdle;
		endfunction

		// A length of N ticks holds for N ticks, and zero behaves as one.
		function logic [LenW-1:0] span(logic [LenW-1:0] n);
			return (n == '0) ? '0 : n - 1'b1;
		endfunction

		function void load_byte(logic [7:0] b);
			shifter   = b;
			bit_idx   = 3'd7;
			ph        = SeqWrLow;
			sclk_lvl  = 1'b0;
			pull_low  = ~b[7];
			countdown = span(timing.half_bit_cycles);
		endfunction

		function void to_idle();
			ph        = SeqIdle;
			sclk_lvl  = 1'b1;
			pull_low  = 1'b0;
			bit_idx   = '0;
			countdown = '0;
		endfunction

		function void note_tick(item_t it);
			result_t want;
			logic    finished;
			finished = 1'b0;
			ticks++;
			if (ph == SeqIdle) begin
				if (it.start_req) begin
					cur_mode    = it.mode;
					second_pass = 1'b0;
					started[it.mode]++;
					case (it.mode)
						ModeRead: load_byte({1'b0, it.address});
						ModeWrite: begin
							held_byte = it.write_data;
							load_byte({1'b0, it.address} | WriteFlag);
						end
						ModeResync: begin
							ph        = SeqRsLow;
							sclk_lvl  = 1'b0;
							pull_low  = 1'b0;
							countdown = span(timing.resync_low_cycles);
						end
						default: load_byte(RegDeltaX);
					endcase
				end
			end else if (countdown != '0) begin
				countdown = countdown - 1'b1;
			end else begin
				case (ph)
					SeqWrLow: begin
						ph        = SeqWrHigh;
						sclk_lvl  = 1'b1;
						countdown = span(timing.half_bit_cycles);
					end
					SeqWrHigh: begin
						if (bit_idx != '0) begin
							bit_idx   = bit_idx - 1'b1;
							ph        = SeqWrLow;
							sclk_lvl  = 1'b0;
							pull_low  = ~shifter[bit_idx];
							countdown = span(timing.half_bit_cycles);
						end else if (cur_mode == ModeWrite) begin
							if (!second_pass) begin
								second_pass = 1'b1;
								load_byte(held_byte);
							end else begin
								to_idle();
								finished = 1'b1;
							end
						end else begin
							// Address sent: let go of the data pin and wait for the turnaround.
							ph        = SeqHold;
							sclk_lvl  = 1'b1;
							pull_low  = 1'b0;
							countdown = span(timing.hold_cycles);
						end
					end
					SeqHold: begin
						ph        = SeqRdLow;
						sclk_lvl  = 1'b0;
						bit_idx   = 3'd7;
						shifter   = '0;
						countdown = span(timing.half_bit_cycles);
					end
					SeqRdLow: begin
						ph        = SeqRdHigh;
						sclk_lvl  = 1'b1;
						countdown = span(timing.half_bit_cycles);
					end
					SeqRdHigh: begin
						shifter[bit_idx] = it.sdio_in;
						if (bit_idx != '0) begin
							bit_idx   = bit_idx - 1'b1;
							ph        = SeqRdLow;
							sclk_lvl  = 1'b0;
							countdown = span(timing.half_bit_cycles);
						end else if (cur_mode == ModePoll && !second_pass) begin
							held_byte   = shifter;
							second_pass = 1'b1;
							load_byte(RegDeltaY);
						end else begin
							if (cur_mode == ModePoll) begin
								last_dx = held_byte;
								last_dy = shifter;
							end else begin
								last_read = shifter;
							end
							to_idle();
							finished = 1'b1;
						end
					end
					SeqRsLow: begin
						ph        = SeqRsWait;
						sclk_lvl  = 1'b1;
						countdown = span(timing.resync_wait_cycles);
					end
					SeqRsWait: begin
						to_idle();
						finished = 1'b1;
					end
					default: to_idle();
				endcase
			end
			if (finished) completed++;
			want.sclk           = sclk_lvl;
			want.sdio_drive_low = pull_low;
			want.busy_res       = (ph != SeqIdle);
			want.done_res       = finished;
			want.read_data      = last_read;
			want.delta_x        = last_dx;
			want.delta_y        = last_dy;
			pin_results.push_back(want);
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task compare_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("result %0d, %s: got %h, want %h", checked, name, got, want));
		endtask

		task check_result(result_t got);
			result_t want;
			checked++;
			if (pin_results.size() == 0) begin
				report($sformatf("result %0d arrived with no tick outstanding", checked));
				return;
			end
			want = pin_results.pop_front();
			compare_field("sclk", got.sclk, want.sclk);
			compare_field("sdio_drive_low", got.sdio_drive_low, want.sdio_drive_low);
			compare_field("busy_res", got.busy_res, want.busy_res);
			compare_field("done_res", got.done_res, want.done_res);
			compare_field("read_data", got.read_data, want.read_data);
			compare_field("delta_x", got.delta_x, want.delta_x);
			compare_field("delta_y", got.delta_y, want.delta_y);
		endtask
	endclass

endpackage

### tb/three_wire_sensor_serial_master_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_wire_sensor_serial_master_tb: testbench of the three-wire serial master
// Feeds pin-sequencer ticks through the valid/ready item channel, predicts the
// result of every tick and checks each result transaction in order. Runs
// directed register reads, writes, resyncs and polls, then random traffic
// under several timing settings from zero to the 20-bit maximum, with random
// gaps and stalls on both channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------

module three_wire_sensor_serial_master_tb;
	import twsm_pkg::*;
	import twsm_tb_pkg::*;

	localparam int unsigned QuietLimit    = 2000;
	localparam int unsigned HoldOffCycles = 64;
	localparam int unsigned SettleCycles  = 10;
	localparam logic [LenW-1:0] LenMax    = '1;

	localparam logic [3:0] AnyMode    = 4'b1111;
	localparam logic [3:0] ResyncOnly = 4'b0001 << ModeResync;
	localparam logic [3:0] NoHold     = (4'b0001 << ModeWrite) | (4'b0001 << ModeResync);
	localparam logic [3:0] NoResync   = AnyMode & ~ResyncOnly;

	typedef enum int {SdioNoise, SdioLow, SdioHigh} sdio_style_e;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_ready;
	item_t            item         = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	result_t          result;
	logic             psel         = 1'b0;
	logic             penable      = 1'b0;
	logic             pwrite       = 1'b0;
	logic [AddrW-1:0] paddr        = '0;
	logic [DataW-1:0] pwdata       = '0;
	logic [DataW-1:0] prdata;
	logic             pready;

	pin_sequencer_scoreboard sb;
	sdio_style_e sdio_style   = SdioNoise;
	bit          idling       = 1'b1;
	bit          hold_off_req = 1'b0;
	bit          valid_up     = 1'b0;
	int unsigned tick_gap     = 0;
	int unsigned holds_done   = 0;
	int unsigned quiet        = 0;

	three_wire_sensor_serial_master u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Ends the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QuietLimit) begin
			$display("Timeout: no transaction for %0d cycles", QuietLimit);
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic pin_level();
		case (sdio_style)
			SdioLow:  return 1'b0;
			SdioHigh: return 1'b1;
			default:  return 1'($urandom_range(0, 1));
		endcase
	endfunction

	// Biased towards the all-zero and all-one extremes.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [LenW-1:0] pick_len();
		return ($urandom_range(0, 7) == 0) ? '0 : LenW'($urandom_range(1, 6));
	endfunction

	// A tick with no new request; while busy some carry a start that must be ignored.
	function automatic item_t filler_tick(input bit may_start);
		item_t it;
		it.start_req  = may_start && ($urandom_range(0, 3) == 0);
		it.mode       = 2'($urandom_range(0, 3));
		it.address    = 7'($urandom_range(0, 127));
		it.write_data = 8'($urandom_range(0, 255));
		it.sdio_in    = pin_level();
		return it;
	endfunction

	task automatic send_tick(input item_t it);
		if (tick_gap != 0) repeat (tick_gap) @(posedge clk);
		item       <= it;
		item_valid <= 1'b1;
		valid_up    = 1'b1;
		do @(posedge clk); while (!item_ready);
		sb.note_tick(it);
		tick_gap = idling ? $urandom_range(0, 5) : 0;
		if (tick_gap != 0) begin
			item_valid <= 1'b0;
			valid_up    = 1'b0;
		end
	endtask

	task automatic hold_items();
		if (valid_up) begin
			item_valid <= 1'b0;
			valid_up    = 1'b0;
		end
	endtask

	task automatic wait_results_drained();
		while (sb.pin_results.size() != 0) @(posedge clk);
	endtask

	task automatic apb_xfer(input bit wr, input logic [1:0] idx,
			input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
		psel   <= 1'b1;
		pwrite <= wr;
		paddr  <= AddrW'({idx, 2'b00});
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		penable <= 1'b0;
	endtask

	task automatic apb_release();
		psel <= 1'b0;
	endtask

	// Upper data bits carry noise; only the low 20 bits belong to the register.
	task automatic write_reg(input logic [1:0] idx, input logic [LenW-1:0] len);
		logic [DataW-1:0] word;
		logic [DataW-1:0] unused;
		word           = $urandom();
		word[LenW-1:0] = len;
		apb_xfer(1'b1, idx, word, unused);
		sb.set_timing(idx, word);
	endtask

	task automatic set_config(input logic [LenW-1:0] half_bit, hold, rs_low, rs_wait);
		hold_items();
		wait_results_drained();
		write_reg(RegHalfBit, half_bit);
		write_reg(RegHold, hold);
		write_reg(RegResyncLow, rs_low);
		write_reg(RegResyncWait, rs_wait);
		apb_release();
	endtask

	task automatic run_transaction(input logic [1:0] mode, input logic [6:0] addr,
			input logic [7:0] wdata, input sdio_style_e style);
		item_t it;
		sdio_style    = style;
		it.start_req  = 1'b1;
		it.mode       = mode;
		it.address    = addr;
		it.write_data = wdata;
		it.sdio_in    = pin_level();
		send_tick(it);
		while (sb.busy()) send_tick(filler_tick(1'b1));
	endtask

	task automatic random_transaction(input logic [3:0] allowed);
		logic [1:0]  mode;
		logic [7:0]  addr;
		sdio_style_e style;
		do mode = 2'($urandom_range(0, 3)); while (!allowed[mode]);
		addr = pick_byte();
		case ($urandom_range(0, 7))
			6:       style = SdioLow;
			7:       style = SdioHigh;
			default: style = SdioNoise;
		endcase
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_tick(filler_tick(1'b0));
		run_transaction(mode, addr[6:0], pick_byte(), style);
	endtask

	task automatic run_phase(input int unsigned n_ticks, input logic [3:0] allowed);
		int unsigned first;
		first = sb.ticks;
		while (sb.ticks - first < n_ticks) random_transaction(allowed);
	endtask

	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = idling ? $urandom_range(0, 5) : 0;
			if (hold_off_req) begin
				stall        = HoldOffCycles;
				hold_off_req = 1'b0;
				holds_done++;
			end
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			sb.check_result(result);
		end
	end

	initial begin
		logic [DataW-1:0] word;
		logic [LenW-1:0]  reset_len [4];
		item_t            poll_tick;
		sb = new();
		reset_len[RegHalfBit]    = HalfBitReset;
		reset_len[RegHold]       = HoldReset;
		reset_len[RegResyncLow]  = ResyncLowReset;
		reset_len[RegResyncWait] = ResyncWaitReset;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 4; i++) begin
			apb_xfer(1'b0, 2'(i), '0, word);
			if (word[LenW-1:0] !== reset_len[i])
				sb.report($sformatf("register %0d reads %h after reset, want %h",
					i, word[LenW-1:0], reset_len[i]));
		end
		apb_release();
		repeat (8) send_tick(filler_tick(1'b0));

		set_config(1, 1, 1, 1);
		run_transaction(ModeRead, 7'h00, 8'h00, SdioLow);
		run_transaction(ModeRead, 7'h7F, 8'hFF, SdioHigh);
		run_transaction(ModeWrite, 7'h7F, 8'hFF, SdioNoise);
		run_transaction(ModeWrite, 7'h00, 8'h00, SdioNoise);
		run_transaction(ModeResync, 7'h55, 8'hAA, SdioNoise);
		run_transaction(ModePoll, 7'h00, 8'h00, SdioHigh);
		run_transaction(ModePoll, 7'h7F, 8'hFF, SdioLow);
		run_transaction(ModePoll, 7'h2A, 8'h5C, SdioNoise);

		// Zero lengths must behave as one tick.
		set_config(0, 0, 0, 0);
		run_transaction(ModeRead, 7'h3C, 8'h00, SdioNoise);
		run_transaction(ModeResync, 7'h01, 8'h01, SdioNoise);
		run_transaction(ModeWrite, 7'h11, 8'h96, SdioNoise);

		// A new half-bit length written during a poll applies from the next phase.
		set_config(2, 1, 1, 2);
		sdio_style           = SdioNoise;
		poll_tick            = filler_tick(1'b0);
		poll_tick.start_req  = 1'b1;
		poll_tick.mode       = ModePoll;
		send_tick(poll_tick);
		repeat (6) send_tick(filler_tick(1'b1));
		hold_items();
		wait_results_drained();
		write_reg(RegHalfBit, 3);
		apb_release();
		while (sb.busy()) send_tick(filler_tick(1'b1));

		for (int p = 0; p < 3; p++) begin
			set_config(pick_len(), pick_len(), pick_len(), pick_len());
			idling       = (p != 1);
			hold_off_req = (p == 1);
			run_phase(250, AnyMode);
		end
		idling = 1'b1;

		// Each register at its maximum, with only the modes that do not wait on it.
		set_config(LenMax, 1, 1, 3);
		run_phase(40, ResyncOnly);
		set_config(2, LenMax, 2, 2);
		run_phase(100, NoHold);
		set_config(1, 1, LenMax, LenMax);
		run_phase(100, NoResync);
		set_config(5, 3, 2, 6);
		run_phase(200, AnyMode);

		hold_items();
		wait_results_drained();
		repeat (SettleCycles) @(posedge clk);

		$display("Checked %0d results over %0d ticks; started %0d reads, %0d writes, %0d resyncs, %0d polls; %0d finished.",
			sb.checked, sb.ticks, sb.started[ModeRead], sb.started[ModeWrite],
			sb.started[ModeResync], sb.started[ModePoll], sb.completed);
		$display("Timing lengths ranged from zero to the 20-bit maximum; result side held off %0d time(s).",
			holds_done);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatch(es)", sb.errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### files.f
design/twsm_pkg.sv
design/twsm_cfg.sv
design/twsm_seq.sv
design/three_wire_sensor_serial_master.sv
tb/twsm_tb_pkg.sv
tb/three_wire_sensor_serial_master_tb.sv
